>>> rtl/dlf_pkg.sv
package dlf_pkg;

    localparam int SAMPLE_BITS_DEF = 24;
    localparam int STATE_BITS_DEF  = 40;
    localparam int FRAC_BITS       = 24;

    localparam int LADDER_COEFF_W   = 23;
    localparam int FEEDBACK_GAIN_W  = 22;
    localparam int OUTPUT_GAIN_W    = 19;
    localparam int HIGHPASS_COEFF_W = 24;

    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LADDER_COEFF   = 2'd0,
        CFG_FEEDBACK_GAIN  = 2'd1,
        CFG_OUTPUT_GAIN    = 2'd2,
        CFG_HIGHPASS_COEFF = 2'd3
    } cfg_idx_t;

endpackage

>>> rtl/diode_ladder_lowpass_filter_unit.sv
// Samples are worked one at a time; s_tready is low from an accepted request until
// its result is loaded into the output register, which waits while that is still full.
// All work runs on one shared multiplier: eight products, four steps each
// (operand, low partial product, high partial product, round and saturate).
// Reset: aresetn synchronous, active low; clears ladder and highpass state,
// coefficient registers and both handshakes.
module diode_ladder_lowpass_filter_unit #(
    parameter int SAMPLE_BITS = dlf_pkg::SAMPLE_BITS_DEF,
    parameter int STATE_BITS  = dlf_pkg::STATE_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // sample_in
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // sample_out
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]      m_tdata,
    // clipped
    output logic                                  m_tuser,
    input  logic                                  cfg_we,
    input  logic [dlf_pkg::CFG_IDX_W-1:0]         cfg_addr,
    input  logic [dlf_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

    localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int FRAC    = dlf_pkg::FRAC_BITS;
    localparam int VW      = STATE_BITS + 2;
    localparam int HW      = VW - FRAC;
    localparam int MAW     = (HW > FRAC + 1) ? HW : FRAC + 1;
    localparam int CW      = FRAC + 1;
    localparam int MPW     = MAW + CW + 1;
    localparam int PW      = VW + CW + 1;
    localparam int UP_SH   = (SAMPLE_BITS - 1 < FRAC) ? FRAC - (SAMPLE_BITS - 1) : 0;
    localparam int DN_SH   = (SAMPLE_BITS - 1 > FRAC) ? (SAMPLE_BITS - 1) - FRAC : 0;
    localparam int DN_HALF = (DN_SH > 0) ? (1 << (DN_SH - 1)) : 0;

    localparam logic [4:0] SH_FB  = 5'd16;
    localparam logic [4:0] SH_HPA = 5'(FRAC + 1);
    localparam logic [4:0] SH_STD = 5'(FRAC);
    localparam logic [4:0] SH_Y1  = 5'(FRAC - 1);
    localparam logic [4:0] SH_OUT = 5'(16 + FRAC - SAMPLE_BITS);

    localparam logic signed [PW-1:0] ST_MAX  = PW'({(STATE_BITS-1){1'b1}});
    localparam logic signed [PW-1:0] ST_MIN  = ~ST_MAX;
    localparam logic signed [PW-1:0] SMP_MAX = PW'({(SAMPLE_BITS-1){1'b1}});
    localparam logic signed [PW-1:0] SMP_MIN = ~SMP_MAX;

    typedef enum logic {ST_IDLE, ST_CALC} state_t;
    typedef enum logic [2:0] {
        OP_FB, OP_HP_A, OP_HP_B, OP_Y1, OP_Y2, OP_Y3, OP_Y4, OP_OUT
    } op_t;
    typedef enum logic [1:0] {PH_PREP, PH_LO, PH_HI, PH_DONE} ph_t;

    function automatic logic signed [STATE_BITS-1:0] sat_st(input logic signed [PW-1:0] v);
        if (v > ST_MAX) return ST_MAX[STATE_BITS-1:0];
        if (v < ST_MIN) return ST_MIN[STATE_BITS-1:0];
        return v[STATE_BITS-1:0];
    endfunction

    function automatic logic clip_st(input logic signed [PW-1:0] v);
        return (v > ST_MAX) || (v < ST_MIN);
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] sat_smp(input logic signed [PW-1:0] v);
        if (v > SMP_MAX) return SMP_MAX[SAMPLE_BITS-1:0];
        if (v < SMP_MIN) return SMP_MIN[SAMPLE_BITS-1:0];
        return v[SAMPLE_BITS-1:0];
    endfunction

    function automatic logic clip_smp(input logic signed [PW-1:0] v);
        return (v > SMP_MAX) || (v < SMP_MIN);
    endfunction

    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    ph_t    ph_reg, ph_next;

    logic [dlf_pkg::LADDER_COEFF_W-1:0]   lad_reg, lad_next;
    logic [dlf_pkg::FEEDBACK_GAIN_W-1:0]  fbk_reg, fbk_next;
    logic [dlf_pkg::OUTPUT_GAIN_W-1:0]    outg_reg, outg_next;
    logic [dlf_pkg::HIGHPASS_COEFF_W-1:0] hpa_reg, hpa_next;

    logic signed [STATE_BITS-1:0] y_reg [4];
    logic signed [STATE_BITS-1:0] y_next [4];
    logic signed [STATE_BITS-1:0] hx_reg, hx_next;
    logic signed [STATE_BITS-1:0] hy_reg, hy_next;
    logic signed [STATE_BITS-1:0] fb_reg, fb_next;
    logic signed [STATE_BITS-1:0] s_reg, s_next;
    logic signed [PW-1:0]         tmp_reg, tmp_next;
    logic signed [PW-1:0]         acc_reg, acc_next;
    logic signed [VW-1:0]         opnd_reg, opnd_next;
    logic [CW-1:0]                coeff_reg, coeff_next;
    logic [4:0]                   shamt_reg, shamt_next;
    logic                         clip_reg, clip_next;

    logic                         m_valid_reg, m_valid_next;
    logic [SAMPLE_BITS-1:0]       m_data_reg, m_data_next;
    logic                         m_clip_reg, m_clip_next;

    logic signed [MAW-1:0]        mul_a;
    logic signed [MPW-1:0]        prod;
    logic signed [PW-1:0]         half_v;
    logic signed [PW-1:0]         neg_v;
    logic signed [PW-1:0]         rnd;
    logic signed [PW-1:0]         sum_v;
    logic signed [PW-1:0]         y0_sum;
    logic signed [STATE_BITS-1:0] y0_v;
    logic signed [SAMPLE_BITS:0]  x_ext;
    logic signed [SAMPLE_BITS:0]  x_rnd;

    assign s_tready = (state_reg == ST_IDLE) && aresetn;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = TDATA_W'(m_data_reg);
    assign m_tuser  = m_clip_reg;

    // shared multiplier: low 24 operand bits unsigned, then the signed upper part
    always_comb begin
        if (ph_reg == PH_LO) begin
            mul_a = MAW'({1'b0, opnd_reg[FRAC-1:0]});
        end else begin
            mul_a = MAW'($signed(opnd_reg[VW-1:FRAC]));
        end
        prod = MPW'(mul_a) * MPW'($signed({1'b0, coeff_reg}));
    end

    assign half_v = PW'(1) << (shamt_reg - 5'd1);
    assign neg_v  = PW'(opnd_reg[VW-1]);
    assign rnd    = acc_reg >>> shamt_reg;

    assign x_ext  = (SAMPLE_BITS + 1)'($signed(s_tdata[SAMPLE_BITS-1:0]));
    assign x_rnd  = (x_ext + (SAMPLE_BITS + 1)'(DN_HALF)
                     - $signed((SAMPLE_BITS + 1)'((DN_SH > 0) && x_ext[SAMPLE_BITS])))
                    >>> DN_SH;

    assign y0_sum = PW'(s_reg) - PW'(hy_reg);
    assign y0_v   = sat_st(y0_sum);

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        ph_next      = ph_reg;
        lad_next     = lad_reg;
        fbk_next     = fbk_reg;
        outg_next    = outg_reg;
        hpa_next     = hpa_reg;
        y_next       = y_reg;
        hx_next      = hx_reg;
        hy_next      = hy_reg;
        fb_next      = fb_reg;
        s_next       = s_reg;
        tmp_next     = tmp_reg;
        acc_next     = acc_reg;
        opnd_next    = opnd_reg;
        coeff_next   = coeff_reg;
        shamt_next   = shamt_reg;
        clip_next    = clip_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_clip_next  = m_clip_reg;
        sum_v        = '0;

        if (cfg_we) begin
            unique case (dlf_pkg::cfg_idx_t'(cfg_addr))
                dlf_pkg::CFG_LADDER_COEFF:   lad_next  = cfg_wdata[dlf_pkg::LADDER_COEFF_W-1:0];
                dlf_pkg::CFG_FEEDBACK_GAIN:  fbk_next  = cfg_wdata[dlf_pkg::FEEDBACK_GAIN_W-1:0];
                dlf_pkg::CFG_OUTPUT_GAIN:    outg_next = cfg_wdata[dlf_pkg::OUTPUT_GAIN_W-1:0];
                dlf_pkg::CFG_HIGHPASS_COEFF: hpa_next  = cfg_wdata[dlf_pkg::HIGHPASS_COEFF_W-1:0];
            endcase
        end

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tready) begin
                    s_next     = STATE_BITS'(x_rnd) <<< UP_SH;
                    clip_next  = 1'b0;
                    op_next    = OP_FB;
                    ph_next    = PH_PREP;
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                unique case (ph_reg)
                    PH_PREP: begin
                        ph_next = PH_LO;
                        unique case (op_reg)
                            OP_FB: begin
                                opnd_next  = VW'(y_reg[3]);
                                coeff_next = CW'(fbk_reg);
                                shamt_next = SH_FB;
                            end
                            OP_HP_A: begin
                                opnd_next  = VW'(fb_reg) - VW'(hx_reg);
                                coeff_next = {1'b1, hpa_reg};
                                shamt_next = SH_HPA;
                            end
                            OP_HP_B: begin
                                opnd_next  = VW'(hy_reg);
                                coeff_next = {1'b0, hpa_reg};
                                shamt_next = SH_STD;
                            end
                            OP_Y1: begin
                                clip_next  = clip_reg | clip_st(y0_sum);
                                opnd_next  = VW'(y0_v) - VW'(y_reg[0]) + VW'(y_reg[1]);
                                coeff_next = CW'(lad_reg);
                                shamt_next = SH_Y1;
                            end
                            OP_Y2: begin
                                opnd_next  = VW'(y_reg[0]) - (VW'(y_reg[1]) <<< 1)
                                             + VW'(y_reg[2]);
                                coeff_next = CW'(lad_reg);
                                shamt_next = SH_STD;
                            end
                            OP_Y3: begin
                                opnd_next  = VW'(y_reg[1]) - (VW'(y_reg[2]) <<< 1)
                                             + VW'(y_reg[3]);
                                coeff_next = CW'(lad_reg);
                                shamt_next = SH_STD;
                            end
                            OP_Y4: begin
                                opnd_next  = VW'(y_reg[2]) - (VW'(y_reg[3]) <<< 1);
                                coeff_next = CW'(lad_reg);
                                shamt_next = SH_STD;
                            end
                            OP_OUT: begin
                                opnd_next  = VW'(y_reg[3]);
                                coeff_next = CW'(outg_reg);
                                shamt_next = SH_OUT;
                            end
                        endcase
                    end
                    PH_LO: begin
                        acc_next = PW'(prod) + half_v - neg_v;
                        ph_next  = PH_HI;
                    end
                    PH_HI: begin
                        acc_next = acc_reg + (PW'(prod) <<< FRAC);
                        ph_next  = PH_DONE;
                    end
                    PH_DONE: begin
                        ph_next = PH_PREP;
                        unique case (op_reg)
                            OP_FB: begin
                                fb_next   = sat_st(rnd);
                                clip_next = clip_reg | clip_st(rnd);
                                op_next   = OP_HP_A;
                            end
                            OP_HP_A: begin
                                tmp_next = rnd;
                                op_next  = OP_HP_B;
                            end
                            OP_HP_B: begin
                                sum_v     = tmp_reg + rnd;
                                hy_next   = sat_st(sum_v);
                                hx_next   = fb_reg;
                                clip_next = clip_reg | clip_st(sum_v);
                                op_next   = OP_Y1;
                            end
                            OP_Y1: begin
                                sum_v     = PW'(y_reg[0]) + rnd;
                                y_next[0] = sat_st(sum_v);
                                clip_next = clip_reg | clip_st(sum_v);
                                op_next   = OP_Y2;
                            end
                            OP_Y2: begin
                                sum_v     = PW'(y_reg[1]) + rnd;
                                y_next[1] = sat_st(sum_v);
                                clip_next = clip_reg | clip_st(sum_v);
                                op_next   = OP_Y3;
                            end
                            OP_Y3: begin
                                sum_v     = PW'(y_reg[2]) + rnd;
                                y_next[2] = sat_st(sum_v);
                                clip_next = clip_reg | clip_st(sum_v);
                                op_next   = OP_Y4;
                            end
                            OP_Y4: begin
                                sum_v     = PW'(y_reg[3]) + rnd;
                                y_next[3] = sat_st(sum_v);
                                clip_next = clip_reg | clip_st(sum_v);
                                op_next   = OP_OUT;
                            end
                            OP_OUT: begin
                                // hold here until the output register is free
                                ph_next = PH_DONE;
                                if (!m_valid_reg || m_tready) begin
                                    m_data_next  = sat_smp(rnd);
                                    m_clip_next  = clip_reg | clip_smp(rnd);
                                    m_valid_next = 1'b1;
                                    ph_next      = PH_PREP;
                                    state_next   = ST_IDLE;
                                end
                            end
                        endcase
                    end
                endcase
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            op_reg      <= OP_FB;
            ph_reg      <= PH_PREP;
            lad_reg     <= '0;
            fbk_reg     <= '0;
            outg_reg    <= '0;
            hpa_reg     <= '0;
            y_reg       <= '{default: '0};
            hx_reg      <= '0;
            hy_reg      <= '0;
            clip_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            ph_reg      <= ph_next;
            lad_reg     <= lad_next;
            fbk_reg     <= fbk_next;
            outg_reg    <= outg_next;
            hpa_reg     <= hpa_next;
            y_reg       <= y_next;
            hx_reg      <= hx_next;
            hy_reg      <= hy_next;
            clip_reg    <= clip_next;
            m_valid_reg <= m_valid_next;
        end
        fb_reg     <= fb_next;
        s_reg      <= s_next;
        tmp_reg    <= tmp_next;
        acc_reg    <= acc_next;
        opnd_reg   <= opnd_next;
        coeff_reg  <= coeff_next;
        shamt_reg  <= shamt_next;
        m_data_reg <= m_data_next;
        m_clip_reg <= m_clip_next;
    end

endmodule

>>> rtl/dlf_checker.sv
module dlf_checker #(
    parameter int SAMPLE_BITS = dlf_pkg::SAMPLE_BITS_DEF
) (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [((SAMPLE_BITS+7)/8)*8-1:0] m_tdata,
    input logic                             m_tuser
);

    a_busy_after_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input still ready after a request was taken");

    a_result_frees_input: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> s_tready)
        else $error("result issued but input not ready");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind diode_ladder_lowpass_filter_unit dlf_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_dlf_checker (.*);

>>> sim/tb_diode_ladder_lowpass_filter_unit.sv
`timescale 1ns / 100ps

module tb_diode_ladder_lowpass_filter_unit;

    localparam int SW          = dlf_pkg::SAMPLE_BITS_DEF;
    localparam int STW         = dlf_pkg::STATE_BITS_DEF;
    localparam int TDATA_W     = ((SW + 7) / 8) * 8;
    localparam int OUT_SHIFT   = 16 + dlf_pkg::FRAC_BITS - (SW - 1) - 1;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_SETTLE = 4;
    localparam int TAIL_CYCLES = 40;
    localparam int CYCLE_LIMIT = 1500000;

    localparam logic signed [SW-1:0] SMP_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SMP_MIN = {1'b1, {(SW-1){1'b0}}};

    typedef struct packed {
        logic [SW-1:0] sample;
        logic          clipped;
    } filter_out_t;

    logic                           aclk;
    logic                           aresetn   = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [TDATA_W-1:0]             s_tdata   = '0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [TDATA_W-1:0]             m_tdata;
    logic                           m_tuser;
    logic                           cfg_we    = 1'b0;
    logic [dlf_pkg::CFG_IDX_W-1:0]  cfg_addr  = '0;
    logic [dlf_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    // predictor copy of coefficients and filter state
    logic [dlf_pkg::LADDER_COEFF_W-1:0]   b_coeff = '0;
    logic [dlf_pkg::FEEDBACK_GAIN_W-1:0]  k_gain  = '0;
    logic [dlf_pkg::OUTPUT_GAIN_W-1:0]    g_out   = '0;
    logic [dlf_pkg::HIGHPASS_COEFF_W-1:0] a_pole  = '0;
    longint st_y [4];
    longint hp_in_prev  = 0;
    longint hp_out_prev = 0;
    bit     clip_seen;

    filter_out_t pending_outs [$];
    filter_out_t head_out;
    logic signed [SW-1:0] last_sample = '0;

    int  mismatch_count = 0;
    int  result_count   = 0;
    int  cycle_count    = 0;
    bit  calm           = 1'b0;
    int  squeeze_asks   = 0;
    int  squeeze_served = 0;
    int  hold_left      = 0;
    int  stall_left     = 0;

    diode_ladder_lowpass_filter_unit #(
        .SAMPLE_BITS (SW),
        .STATE_BITS  (STW)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic longint scale_round(longint v, longint unsigned c, int sh);
        logic [127:0] mag;
        logic [127:0] prod;
        mag  = (v < 0) ? 128'(-v) : 128'(v);
        prod = (mag * 128'(c) + (128'(1) << (sh - 1))) >> sh;
        return (v < 0) ? -$signed(prod[63:0]) : $signed(prod[63:0]);
    endfunction

    function automatic longint clamp(longint v, int bits);
        longint hi;
        longint lo;
        hi = (longint'(1) << (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin
            clip_seen = 1'b1;
            return hi;
        end
        if (v < lo) begin
            clip_seen = 1'b1;
            return lo;
        end
        return v;
    endfunction

    task automatic ladder_step(logic signed [SW-1:0] smp);
        longint s;
        longint fb;
        longint hp;
        longint y0;
        longint d;
        longint res;
        filter_out_t r;
        clip_seen = 1'b0;
        s  = longint'(smp) <<< (dlf_pkg::FRAC_BITS - (SW - 1));
        fb = clamp(scale_round(st_y[3], k_gain, 16), STW);
        hp = clamp(scale_round(fb - hp_in_prev,
                               (64'd1 << dlf_pkg::FRAC_BITS) + 64'(a_pole),
                               dlf_pkg::FRAC_BITS + 1)
                   + scale_round(hp_out_prev, a_pole, dlf_pkg::FRAC_BITS), STW);
        hp_in_prev  = fb;
        hp_out_prev = hp;
        y0 = clamp(s - hp, STW);
        d = y0 - st_y[0] + st_y[1];
        st_y[0] = clamp(st_y[0] + scale_round(d, b_coeff, dlf_pkg::FRAC_BITS - 1), STW);
        d = st_y[0] - 2 * st_y[1] + st_y[2];
        st_y[1] = clamp(st_y[1] + scale_round(d, b_coeff, dlf_pkg::FRAC_BITS), STW);
        d = st_y[1] - 2 * st_y[2] + st_y[3];
        st_y[2] = clamp(st_y[2] + scale_round(d, b_coeff, dlf_pkg::FRAC_BITS), STW);
        d = st_y[2] - 2 * st_y[3];
        st_y[3] = clamp(st_y[3] + scale_round(d, b_coeff, dlf_pkg::FRAC_BITS), STW);
        res = clamp(scale_round(st_y[3], g_out, OUT_SHIFT), SW);
        r.sample  = res[SW-1:0];
        r.clipped = clip_seen;
        pending_outs.push_back(r);
    endtask

    function automatic int pick_gap();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 4);
    endfunction

    function automatic int sender_gap();
        if (calm || $urandom_range(0, 1) == 0)
            return 0;
        return pick_gap();
    endfunction

    function automatic logic signed [SW-1:0] next_sample();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick <= 3)
            last_sample = SW'($urandom);
        else if (pick <= 5)
            last_sample = SW'($urandom_range(0, 8191)) - SW'(4096);
        else if (pick == 6)
            last_sample = $urandom_range(0, 1) ? SMP_MAX : SMP_MIN;
        return last_sample;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("ERROR %s: got %0d expected %0d at result %0d",
                 what, got, want, result_count);
        mismatch_count++;
    endtask

    // hold each request until the block takes it, then predict its result
    task automatic offer_sample(logic signed [SW-1:0] smp);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= TDATA_W'(smp);
        do @(posedge aclk); while (!s_tready);
        ladder_step(smp);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_outs.size() != 0) @(posedge aclk);
        repeat (IDLE_SETTLE) @(posedge aclk);
    endtask

    task automatic load_coeffs(logic [dlf_pkg::CFG_DATA_W-1:0] b,
                               logic [dlf_pkg::CFG_DATA_W-1:0] k,
                               logic [dlf_pkg::CFG_DATA_W-1:0] g,
                               logic [dlf_pkg::CFG_DATA_W-1:0] a);
        logic [dlf_pkg::CFG_DATA_W-1:0] vals [4];
        dlf_pkg::cfg_idx_t regs [4];
        vals = '{b, k, g, a};
        regs = '{dlf_pkg::CFG_LADDER_COEFF, dlf_pkg::CFG_FEEDBACK_GAIN,
                 dlf_pkg::CFG_OUTPUT_GAIN, dlf_pkg::CFG_HIGHPASS_COEFF};
        wait_idle();
        cfg_we <= 1'b1;
        for (int i = 0; i < 4; i++) begin
            cfg_addr  <= regs[i];
            cfg_wdata <= vals[i];
            @(posedge aclk);
        end
        cfg_we  <= 1'b0;
        b_coeff = b[dlf_pkg::LADDER_COEFF_W-1:0];
        k_gain  = k[dlf_pkg::FEEDBACK_GAIN_W-1:0];
        g_out   = g[dlf_pkg::OUTPUT_GAIN_W-1:0];
        a_pole  = a[dlf_pkg::HIGHPASS_COEFF_W-1:0];
    endtask

    // upper junk bits above each narrower register width must be dropped
    task automatic load_random_coeffs();
        logic [dlf_pkg::CFG_DATA_W-1:0] b;
        logic [dlf_pkg::CFG_DATA_W-1:0] k;
        logic [dlf_pkg::CFG_DATA_W-1:0] g;
        logic [dlf_pkg::CFG_DATA_W-1:0] a;
        b = dlf_pkg::CFG_DATA_W'($urandom);
        k = dlf_pkg::CFG_DATA_W'($urandom);
        g = dlf_pkg::CFG_DATA_W'($urandom);
        a = dlf_pkg::CFG_DATA_W'($urandom);
        if ($urandom_range(0, 2) != 0) begin
            b[dlf_pkg::LADDER_COEFF_W-1:0]   =
                dlf_pkg::LADDER_COEFF_W'($urandom_range(24'h010000, 24'h300000));
            k[dlf_pkg::FEEDBACK_GAIN_W-1:0]  =
                dlf_pkg::FEEDBACK_GAIN_W'($urandom_range(0, 17 << 16));
            a[dlf_pkg::HIGHPASS_COEFF_W-1:0] =
                dlf_pkg::HIGHPASS_COEFF_W'($urandom_range(24'hF00000, 24'hFFFFFF));
        end
        load_coeffs(b, k, g, a);
    endtask

    task automatic stream_random(int count);
        repeat (count) offer_sample(next_sample());
    endtask

    task automatic test_reset_coeffs();
        offer_sample('0);
        offer_sample(SMP_MAX);
        offer_sample(SMP_MIN);
    endtask

    task automatic test_sample_extremes();
        logic signed [SW-1:0] pts [7];
        pts = '{SMP_MAX, SMP_MIN, '0, '1, SW'(1), SW'(24'h555555), SW'(24'hAAAAAA)};
        load_coeffs(24'h200000, 24'(4 << 16), 24'(2 << 16), 24'hF80000);
        foreach (pts[i]) offer_sample(pts[i]);
    endtask

    task automatic test_saturation();
        load_coeffs(24'h7FFFFF, 24'h3FFFFF, 24'h07FFFF, 24'hFFFFFF);
        repeat (4) offer_sample(SMP_MAX);
        repeat (4) offer_sample(SMP_MIN);
    endtask

    task automatic test_wide_writes();
        load_coeffs('1, '1, '1, '1);
        offer_sample(SMP_MIN);
        offer_sample(SMP_MAX);
        offer_sample('0);
        offer_sample(SW'(24'h123456));
        offer_sample(SW'(24'hEDCBA9));
    endtask

    task automatic test_random_settings();
        load_coeffs(24'h7FFFFF, '0, 24'h07FFFF, '0);
        stream_random(260);
        repeat (4) begin
            load_random_coeffs();
            stream_random(260);
        end
    endtask

    task automatic test_backpressure();
        load_random_coeffs();
        squeeze_asks++;
        stream_random(100);
        squeeze_asks++;
        stream_random(100);
    endtask

    task automatic test_steady_stream();
        load_random_coeffs();
        calm = 1'b1;
        stream_random(300);
        calm = 1'b0;
    endtask

    // receiver: random stalls plus a long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (squeeze_asks != squeeze_served) begin
            squeeze_served = squeeze_asks;
            hold_left      = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (!calm && $urandom_range(0, 7) == 0)
                stall_left = pick_gap();
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_outs.size() == 0) begin
                report_mismatch("unexpected result, sample_out", $signed(m_tdata[SW-1:0]), 0);
            end else begin
                head_out = pending_outs.pop_front();
                if (m_tdata[SW-1:0] !== head_out.sample)
                    report_mismatch("sample_out", $signed(m_tdata[SW-1:0]),
                                    $signed(head_out.sample));
                if (m_tuser !== head_out.clipped)
                    report_mismatch("clipped", m_tuser, head_out.clipped);
            end
            result_count++;
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("diode_ladder_lowpass_filter_unit: mismatch");
        $finish;
    end

    initial begin
        foreach (st_y[i]) st_y[i] = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_coeffs();
        test_sample_extremes();
        test_saturation();
        test_wide_writes();
        test_random_settings();
        test_backpressure();
        test_steady_stream();
        s_tvalid <= 1'b0;
        while (pending_outs.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("diode_ladder_lowpass_filter_unit: match");
        else
            $display("diode_ladder_lowpass_filter_unit: mismatch");
        $finish;
    end

endmodule
